@@ rtl/sorted_union_distinct_unit_assert.svh @@
// Assertion helpers for the sorted union block.
// Both expect clk and rst_n in the scope where they are used.
`ifndef SORTED_UNION_DISTINCT_UNIT_ASSERT_SVH
`define SORTED_UNION_DISTINCT_UNIT_ASSERT_SVH

// same-cycle implication
`define SUD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SUD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sud_pkg.sv @@
package sud_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // request type codes on the input port
    localparam logic [1:0] REQ_APPEND_A = 2'd0;
    localparam logic [1:0] REQ_APPEND_B = 2'd1;
    localparam logic [1:0] REQ_RUN      = 2'd2;

    typedef struct packed {
        logic [1:0]          req_type;
        logic signed [31:0]  value;
    } req_t;

    typedef struct packed {
        logic signed [31:0]  elem;
        logic                elem_valid;
        logic                last;
        logic                overflow;
    } res_t;

    typedef enum logic [1:0] {
        OP_APPEND_A,
        OP_APPEND_B,
        OP_RUN
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic signed [31:0]  value;
    } qent_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic   valid;
        qent_t  entry;
    } q2b_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

endpackage

@@ rtl/sud_front.sv @@
module sud_front
    import sud_pkg::*;
(
    input  logic   start,
    input  req_t   req,
    input  logic   q_full,
    output logic   busy,
    output logic   push,
    output qent_t  push_ent
);

    logic known;

    always_comb
    begin
        known       = 1'b1;
        push_ent.op = OP_APPEND_A;
        unique case (req.req_type)
            REQ_APPEND_A: push_ent.op = OP_APPEND_A;
            REQ_APPEND_B: push_ent.op = OP_APPEND_B;
            REQ_RUN:      push_ent.op = OP_RUN;
            default:      known       = 1'b0;   // unused code, dropped here
        endcase
        push_ent.value = req.value;
    end

    assign busy = q_full;
    assign push = start && !q_full && known;

endmodule

@@ rtl/sud_queue.sv @@
module sud_queue
    import sud_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  qent_t  push_ent,
    input  logic   pop,
    output logic   full,
    output q2b_t   head
);

    qent_t             slot [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full    = (fill_reg == QCNT_W'(QDEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && (fill_reg != '0);

    assign head.valid = (fill_reg != '0);
    assign head.entry = slot[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot[wr_ptr_reg] <= push_ent;
        end
    end

endmodule

@@ rtl/sud_back.sv @@
`include "sorted_union_distinct_unit_assert.svh"

module sud_back
    import sud_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  q2b_t  head,
    output logic  pop,
    output logic  strobe,
    output res_t  result
);

    state_t state_reg, state_next;

    logic [31:0] mem_a [DEPTH];
    logic [31:0] mem_b [DEPTH];

    logic [CNT_W-1:0]   count_a_reg, count_a_next;
    logic [CNT_W-1:0]   count_b_reg, count_b_next;
    logic               dropped_reg, dropped_next;

    // walk indexes; during a run read data matches mem[idx]
    logic [CNT_W-1:0]   ia_reg, ia_next;
    logic [CNT_W-1:0]   ib_reg, ib_next;
    logic signed [31:0] qa_reg, qb_reg;
    // skip mode: last emitted value of each list
    logic               skip_a_reg, skip_a_next;
    logic               skip_b_reg, skip_b_next;
    logic signed [31:0] ta_reg, ta_next;
    logic signed [31:0] tb_reg, tb_next;

    // one-deep hold so the final result can carry last
    logic               pend_vld_reg, pend_vld_next;
    logic signed [31:0] pend_reg, pend_next;

    logic               strobe_reg, strobe_next;
    res_t               result_reg, result_next;

    logic wr_a, wr_b, is_run;
    logic ok_a, ok_b, av_a, av_b, take_a, take_b, done;
    logic signed [31:0] pick;

    assign pop    = (state_reg == ST_IDLE) && head.valid;
    assign is_run = pop && (head.entry.op == OP_RUN);
    assign wr_a   = pop && (head.entry.op == OP_APPEND_A) && (count_a_reg < CNT_W'(DEPTH));
    assign wr_b   = pop && (head.entry.op == OP_APPEND_B) && (count_b_reg < CNT_W'(DEPTH));

    // merge step decode
    always_comb
    begin
        ok_a   = !skip_a_reg || (ia_reg >= count_a_reg) || (qa_reg != ta_reg);
        ok_b   = !skip_b_reg || (ib_reg >= count_b_reg) || (qb_reg != tb_reg);
        av_a   = ia_reg < count_a_reg;
        av_b   = ib_reg < count_b_reg;
        take_a = 1'b0;
        take_b = 1'b0;
        if (ok_a && ok_b)
        begin
            if (av_a && av_b)
            begin
                take_a = !(qb_reg < qa_reg);
                take_b = !(qa_reg < qb_reg);
            end
            else
            begin
                take_a = av_a;
                take_b = av_b;
            end
        end
        done = ok_a && ok_b && !av_a && !av_b;
        pick = take_a ? qa_reg : qb_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (is_run) state_next = ST_RUN;
            ST_RUN:  if (done)   state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_a_next  = count_a_reg;
        count_b_next  = count_b_reg;
        dropped_next  = dropped_reg;
        ia_next       = ia_reg;
        ib_next       = ib_reg;
        skip_a_next   = skip_a_reg;
        skip_b_next   = skip_b_reg;
        ta_next       = ta_reg;
        tb_next       = tb_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        strobe_next   = 1'b0;
        result_next   = result_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                ia_next     = '0;
                ib_next     = '0;
                skip_a_next = 1'b0;
                skip_b_next = 1'b0;
                if (wr_a)
                begin
                    count_a_next = count_a_reg + 1'b1;
                end
                if (wr_b)
                begin
                    count_b_next = count_b_reg + 1'b1;
                end
                if (pop && !is_run && !wr_a && !wr_b)
                begin
                    dropped_next = 1'b1;
                end
            end
            ST_RUN:
            begin
                if (done)
                begin
                    strobe_next            = 1'b1;
                    result_next.elem       = pend_vld_reg ? pend_reg : '0;
                    result_next.elem_valid = pend_vld_reg;
                    result_next.last       = 1'b1;
                    result_next.overflow   = dropped_reg;
                    pend_vld_next          = 1'b0;
                    count_a_next           = '0;
                    count_b_next           = '0;
                    dropped_next           = 1'b0;
                    ia_next                = '0;
                    ib_next                = '0;
                    skip_a_next            = 1'b0;
                    skip_b_next            = 1'b0;
                end
                else if (ok_a && ok_b)
                begin
                    if (pend_vld_reg)
                    begin
                        strobe_next            = 1'b1;
                        result_next.elem       = pend_reg;
                        result_next.elem_valid = 1'b1;
                        result_next.last       = 1'b0;
                        result_next.overflow   = dropped_reg;
                    end
                    pend_vld_next = 1'b1;
                    pend_next     = pick;
                    skip_a_next   = take_a;
                    skip_b_next   = take_b;
                    if (take_a)
                    begin
                        ta_next = qa_reg;
                        ia_next = ia_reg + 1'b1;
                    end
                    if (take_b)
                    begin
                        tb_next = qb_reg;
                        ib_next = ib_reg + 1'b1;
                    end
                end
                else
                begin
                    // a list still inside a run of equal values steps on
                    if (!ok_a)
                    begin
                        ia_next = ia_reg + 1'b1;
                    end
                    else
                    begin
                        skip_a_next = 1'b0;
                    end
                    if (!ok_b)
                    begin
                        ib_next = ib_reg + 1'b1;
                    end
                    else
                    begin
                        skip_b_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_a_reg  <= '0;
            count_b_reg  <= '0;
            dropped_reg  <= 1'b0;
            ia_reg       <= '0;
            ib_reg       <= '0;
            skip_a_reg   <= 1'b0;
            skip_b_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_a_reg  <= count_a_next;
            count_b_reg  <= count_b_next;
            dropped_reg  <= dropped_next;
            ia_reg       <= ia_next;
            ib_reg       <= ib_next;
            skip_a_reg   <= skip_a_next;
            skip_b_reg   <= skip_b_next;
            pend_vld_reg <= pend_vld_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ta_reg     <= ta_next;
        tb_reg     <= tb_next;
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    // stores: read at the next index so q matches mem[idx] in each cycle of a run
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[count_a_reg[ADDR_W-1:0]] <= head.entry.value;
        end
        qa_reg <= mem_a[ia_next[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            mem_b[count_b_reg[ADDR_W-1:0]] <= head.entry.value;
        end
        qb_reg <= mem_b[ib_next[ADDR_W-1:0]];
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    `SUD_ASSERT_NOW(a_idx_bound, state_reg == ST_RUN, (ia_reg <= count_a_reg) && (ib_reg <= count_b_reg), "walk index past list count")
    `SUD_ASSERT_NOW(a_empty_last, strobe_reg && !result_reg.elem_valid, result_reg.last, "empty result without last")
    `SUD_ASSERT_NOW(a_last_idle, strobe_reg && result_reg.last, state_reg == ST_IDLE, "last result while run still active")
    `SUD_ASSERT_NEXT(a_clear_after_run, (state_reg == ST_RUN) && done, (count_a_reg == '0) && (count_b_reg == '0) && !dropped_reg && !pend_vld_reg, "state not cleared after run")

endmodule

@@ rtl/sorted_union_distinct_unit.sv @@
// Sorted union without repeats. Requests are taken when start is high and
// busy is low: append to list A, append to list B (up to DEPTH entries each,
// extra appends are dropped and flagged as overflow), or run. Appends go
// through a 4-entry request queue and retire one per cycle while no run is
// active, so a stream of appends is taken back to back. A run walks both
// stores through their single read ports, one merge step per cycle; while it
// runs the queue keeps taking requests and busy rises only when the queue is
// full. Results come out at most one per cycle on result, each for exactly
// one cycle with strobe high; the receiver cannot stall, so every strobe
// cycle must be captured. The first result of a run leaves only once the
// walk has picked the next element or ended, since each element is held
// until the walk knows whether it is the last one. An empty union gives one
// result with elem_valid low and last high. Counts and the overflow flag
// clear when the run completes.
module sorted_union_distinct_unit
    import sud_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  req_t  req,
    output logic  busy,
    output logic  strobe,
    output res_t  result
);

    logic  q_full;
    logic  push;
    qent_t push_ent;
    logic  pop;
    q2b_t  q_head;

    // decode request type, unused codes never enter the queue
    sud_front u_front
    (
        .start    (start),
        .req      (req),
        .q_full   (q_full),
        .busy     (busy),
        .push     (push),
        .push_ent (push_ent)
    );

    // decouples request intake from the merge walk
    sud_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_ent (push_ent),
        .pop      (pop),
        .full     (q_full),
        .head     (q_head)
    );

    // list stores, counts and the merge engine
    sud_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .pop      (pop),
        .strobe   (strobe),
        .result   (result)
    );

endmodule
